[design/chist_pkg.sv]
// Shared types and constants for the channel histogram block.
`default_nettype none

package chist_pkg;

    // Default sizes for the histogram store
    localparam int BIN_COUNT_DEF   = 256;
    localparam int COUNT_WIDTH_DEF = 21;

    // Fixed field widths
    localparam int SAMPLE_W    = 8;
    localparam int HEIGHT_W    = 10;
    localparam int CHANNEL_W   = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 10;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Channel codes
    localparam logic [CHANNEL_W-1:0] CH_BLUE  = 2'd0;
    localparam logic [CHANNEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CHANNEL_W-1:0] CH_RED   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_SELECT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CANVAS_HEIGHT  = 1'd1;

    // Configuration reset values
    localparam logic [CHANNEL_W-1:0] CHANNEL_RESET = CH_BLUE;
    localparam logic [HEIGHT_W-1:0]  HEIGHT_RESET  = 10'd125;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic cnt_write;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic use_div;
        logic div_last;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[design/chist_ctrl.sv]
// Controller state machine for the channel histogram block.
`default_nettype none

module chist_ctrl
    import chist_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [MODE_W-1:0] mode,
    input  wire dp_status_t        status,
    output logic                   in_ready,
    output dp_cmd_t                cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_COUNT: state_next = S_COUNT;
                        MODE_READ:  state_next = S_MUL;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_COUNT:
            begin
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                state_next = status.use_div ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                state_next = status.div_last ? S_DONE : S_DIV;
            end
            S_DONE:
            begin
                state_next = status.out_busy ? S_DONE : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.clear   = in_valid && (mode == MODE_CLEAR);
            end
            S_COUNT:
            begin
                cmd.cnt_write = 1'b1;
            end
            S_MUL:
            begin
                cmd.div_init = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/chist_datapath.sv]
// Datapath: bin store, peak, configuration, bar scaling divider and output word.
`default_nettype none

module chist_datapath
    import chist_pkg::*;
#(
    parameter int BIN_COUNT   = BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [SAMPLE_W-1:0]    blue_sample,
    input  wire logic [SAMPLE_W-1:0]    green_sample,
    input  wire logic [SAMPLE_W-1:0]    red_sample,
    input  wire logic [SAMPLE_W-1:0]    query_bin,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_W-1:0]         bin_number,
    output logic [COUNT_WIDTH-1:0]      bin_count,
    output logic [HEIGHT_W-1:0]         bar_top,
    output logic [COUNT_WIDTH-1:0]      peak_count
);

    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int P_W    = COUNT_WIDTH + HEIGHT_W;
    localparam int STEP_W = $clog2(HEIGHT_W);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SAMPLE_W:0] LAST_BIN_EXT = (SAMPLE_W+1)'(BIN_COUNT - 1);
    localparam logic [BIN_W-1:0]  LAST_BIN     = BIN_W'(BIN_COUNT - 1);

    // Bin store and its per-entry valid bits
    logic [COUNT_WIDTH-1:0] bin_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0]   valid_reg;

    logic [CHANNEL_W-1:0]   channel_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [COUNT_WIDTH-1:0] peak_reg;
    logic [BIN_W-1:0]       idx_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [HEIGHT_W-1:0]    quo_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_W-1:0]    bin_number_reg;
    logic [COUNT_WIDTH-1:0] bin_count_reg;
    logic [HEIGHT_W-1:0]    bar_top_reg;
    logic [COUNT_WIDTH-1:0] peak_count_reg;

    logic [SAMPLE_W-1:0]    sel_sample;
    logic [BIN_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] count_cur;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [P_W-1:0]         product;
    logic [COUNT_WIDTH:0]   div_trial;
    logic [COUNT_WIDTH:0]   div_diff;
    logic                   div_bit;
    logic                   use_div;
    logic [P_W-1:0]         drop_ext;
    logic [P_W-1:0]         height_ext;
    logic [P_W-1:0]         bar_diff;
    logic [HEIGHT_W-1:0]    bar_value;

    // Sample values past the last bin fold into the last bin.
    function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W:0] v_ext;
        v_ext = {1'b0, v};
        if (v_ext >= LAST_BIN_EXT)
        begin
            return LAST_BIN;
        end
        return v[BIN_W-1:0];
    endfunction

    // Channel selection; the unused code counts blue.
    always_comb
    begin
        case (channel_reg)
            CH_GREEN: sel_sample = green_sample;
            CH_RED:   sel_sample = red_sample;
            default:  sel_sample = blue_sample;
        endcase
    end

    assign rd_addr = (mode == MODE_READ) ? bin_of(query_bin) : bin_of(sel_sample);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= CHANNEL_RESET;
            height_reg  <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CHANNEL_SELECT: channel_reg <= cfg_data[CHANNEL_W-1:0];
                REG_CANVAS_HEIGHT:  height_reg  <= cfg_data[HEIGHT_W-1:0];
                default:            height_reg  <= height_reg;
            endcase
        end
    end

    // Store read, registered; the address is captured for the write back.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= bin_mem[rd_addr];
            idx_reg     <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // An entry that has not been written since the last clear reads as zero.
    assign count_cur = rd_valid_reg ? rd_data_reg : '0;
    assign count_inc = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;

    // Store write
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_write)
        begin
            bin_mem[idx_reg] <= count_inc;
        end
    end

    // Valid bits: a clear drops them all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.cnt_write)
        begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Running peak
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else if (cmd.clear)
        begin
            peak_reg <= '0;
        end
        else if (cmd.cnt_write && (count_inc > peak_reg))
        begin
            peak_reg <= count_inc;
        end
    end

    // Scaling product count * height, split into remainder and quotient halves.
    assign product = P_W'(count_cur) * P_W'(height_reg);

    // One quotient bit a step; the upper half is always below the peak
    // because no bin count exceeds the peak.
    assign div_trial = {rem_reg, quo_reg[HEIGHT_W-1]};
    assign div_diff  = div_trial - {1'b0, peak_reg};
    assign div_bit   = (div_trial >= {1'b0, peak_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            cnt_reg  <= count_cur;
            rem_reg  <= product[P_W-1:HEIGHT_W];
            quo_reg  <= product[HEIGHT_W-1:0];
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_bit ? div_diff[COUNT_WIDTH-1:0] : div_trial[COUNT_WIDTH-1:0];
            quo_reg  <= {quo_reg[HEIGHT_W-2:0], div_bit};
            step_reg <= step_reg + 1'b1;
        end
    end

    // Bar top: scaled drop when the peak exceeds the height, clamped at zero.
    assign height_ext = P_W'(height_reg);
    assign use_div    = P_W'(peak_reg) > height_ext;
    assign drop_ext   = use_div ? P_W'(quo_reg) : P_W'(cnt_reg);
    assign bar_diff   = height_ext - drop_ext;
    assign bar_value  = (drop_ext > height_ext) ? '0 : bar_diff[HEIGHT_W-1:0];

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            bin_number_reg <= SAMPLE_W'(idx_reg);
            bin_count_reg  <= cnt_reg;
            bar_top_reg    <= bar_value;
            peak_count_reg <= peak_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_number = bin_number_reg;
    assign bin_count  = bin_count_reg;
    assign bar_top    = bar_top_reg;
    assign peak_count = peak_count_reg;

    // Status to the controller
    assign status.use_div  = use_div;
    assign status.div_last = (step_reg == STEP_W'(HEIGHT_W - 1));
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

[design/channel_histogram_with_bar_scaling.sv]
// Top level of the channel histogram with bar scaling.
//
//   Channel  Handshake             Word
//   in       in_valid/in_ready     mode, blue/green/red_sample, query_bin
//   out      out_valid/out_ready   bin_number, bin_count, bar_top, peak_count
//   cfg      cfg_write             cfg_index, cfg_data (no back-pressure)
//
// A pixel word is a registered store read followed by a write back.
// A read word is a registered store read and a scaling multiply, then, when
// the peak exceeds the canvas height, the one-bit-per-cycle divider for the bar.
// A clear word is taken while idle; the store's valid bits are dropped at once.
// Reset clears the store and the peak in the same way and resets the registers.
// A finished read waits in the output register; new input words are taken
// meanwhile, and only the next read stalls until that result is taken.
`default_nettype none

module channel_histogram_with_bar_scaling
    import chist_pkg::*;
#(
    parameter int BIN_COUNT   = BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [SAMPLE_W-1:0]    blue_sample,
    input  wire logic [SAMPLE_W-1:0]    green_sample,
    input  wire logic [SAMPLE_W-1:0]    red_sample,
    input  wire logic [SAMPLE_W-1:0]    query_bin,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [SAMPLE_W-1:0]         bin_number,
    output logic [COUNT_WIDTH-1:0]      bin_count,
    output logic [HEIGHT_W-1:0]         bar_top,
    output logic [COUNT_WIDTH-1:0]      peak_count,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller
    chist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath
    chist_datapath #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .blue_sample  (blue_sample),
        .green_sample (green_sample),
        .red_sample   (red_sample),
        .query_bin    (query_bin),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bin_number   (bin_number),
        .bin_count    (bin_count),
        .bar_top      (bar_top),
        .peak_count   (peak_count)
    );

endmodule

`default_nettype wire

[dv/histogram_checker.sv]
// Checker for the channel histogram: predicts each read result and compares it.
module histogram_checker
    import chist_pkg::*;
#(
    parameter int BIN_COUNT   = BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [SAMPLE_W-1:0]    blue_sample,
    input  wire logic [SAMPLE_W-1:0]    green_sample,
    input  wire logic [SAMPLE_W-1:0]    red_sample,
    input  wire logic [SAMPLE_W-1:0]    query_bin,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [SAMPLE_W-1:0]    bin_number,
    input  wire logic [COUNT_WIDTH-1:0] bin_count,
    input  wire logic [HEIGHT_W-1:0]    bar_top,
    input  wire logic [COUNT_WIDTH-1:0] peak_count,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          pending,
    output int                          reads_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = '1;
    localparam int                     PRINT_LIMIT = 40;

    // One expected read result
    typedef struct packed {
        logic [SAMPLE_W-1:0]    bin;
        logic [COUNT_WIDTH-1:0] count;
        logic [HEIGHT_W-1:0]    top;
        logic [COUNT_WIDTH-1:0] peak;
    } readout_t;

    logic [COUNT_WIDTH-1:0] tally [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] peak;
    logic [CHANNEL_W-1:0]   channel;
    logic [HEIGHT_W-1:0]    height;
    readout_t               readout_q [$];

    // Values past the last bin fall into the last bin.
    function automatic int bin_of(input logic [SAMPLE_W-1:0] v);
        return (int'(v) >= BIN_COUNT) ? BIN_COUNT - 1 : int'(v);
    endfunction

    // Bars are scaled against the peak only when the peak is taller than the canvas.
    function automatic logic [HEIGHT_W-1:0] bar_row(input longint unsigned count,
                                                    input longint unsigned top_count,
                                                    input longint unsigned h);
        longint unsigned drop;
        drop = (top_count > h) ? (count * h) / top_count : count;
        return (drop > h) ? '0 : HEIGHT_W'(h - drop);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns  mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Results are compared before the input word of the same edge is predicted,
    // since a read never completes in the cycle it is taken.
    always @(posedge clk) begin
        readout_t             want;
        logic [SAMPLE_W-1:0]  s;
        int                   b;
        if (!rst_n) begin
            foreach (tally[i])
                tally[i] = '0;
            peak          = '0;
            channel       = CHANNEL_RESET;
            height        = HEIGHT_RESET;
            readout_q.delete();
            pending       = 0;
            mismatches    = 0;
            reads_checked = 0;
        end
        else begin
            // Output side
            if (out_valid && out_ready) begin
                if (readout_q.size() == 0) begin
                    report_mismatch($sformatf("result word for bin %0d with none expected",
                                              bin_number));
                end
                else begin
                    want = readout_q.pop_front();
                    reads_checked++;
                    if (bin_number !== want.bin)
                        report_mismatch($sformatf("bin_number got %0d, expected %0d",
                                                  bin_number, want.bin));
                    if (bin_count !== want.count)
                        report_mismatch($sformatf("bin_count of bin %0d got %0d, expected %0d",
                                                  want.bin, bin_count, want.count));
                    if (bar_top !== want.top)
                        report_mismatch($sformatf("bar_top of bin %0d got %0d, expected %0d",
                                                  want.bin, bar_top, want.top));
                    if (peak_count !== want.peak)
                        report_mismatch($sformatf("peak_count got %0d, expected %0d",
                                                  peak_count, want.peak));
                end
            end

            // Register writes
            if (cfg_write) begin
                if (cfg_index == REG_CHANNEL_SELECT)
                    channel = cfg_data[CHANNEL_W-1:0];
                else if (cfg_index == REG_CANVAS_HEIGHT)
                    height = cfg_data[HEIGHT_W-1:0];
            end

            // Input side
            if (in_valid && in_ready) begin
                case (mode)
                    MODE_COUNT: begin
                        case (channel)
                            CH_GREEN: s = green_sample;
                            CH_RED:   s = red_sample;
                            default:  s = blue_sample;
                        endcase
                        b = bin_of(s);
                        if (tally[b] != COUNT_MAX)
                            tally[b] = tally[b] + 1'b1;
                        if (tally[b] > peak)
                            peak = tally[b];
                    end
                    MODE_READ: begin
                        b          = bin_of(query_bin);
                        want.bin   = SAMPLE_W'(b);
                        want.count = tally[b];
                        want.top   = bar_row(tally[b], peak, height);
                        want.peak  = peak;
                        readout_q.push_back(want);
                    end
                    MODE_CLEAR: begin
                        foreach (tally[i])
                            tally[i] = '0;
                        peak = '0;
                    end
                    default: ;
                endcase
            end
            pending = readout_q.size();
        end
    end

endmodule

[dv/testbench.sv]
// Top of the histogram testbench: clock, reset, stimulus and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import chist_pkg::*;

    localparam int                   CYCLE_LIMIT     = 400_000;
    localparam int                   SETTLE_CYCLES   = 20;
    localparam int                   PHASES          = 8;
    localparam int                   WORDS_PER_PHASE = 244;
    localparam logic [MODE_W-1:0]    MODE_UNUSED     = 2'd3;
    localparam logic [CHANNEL_W-1:0] CH_UNUSED       = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [MODE_W-1:0]           mode;
    logic [SAMPLE_W-1:0]         blue_sample;
    logic [SAMPLE_W-1:0]         green_sample;
    logic [SAMPLE_W-1:0]         red_sample;
    logic [SAMPLE_W-1:0]         query_bin;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [SAMPLE_W-1:0]         bin_number;
    logic [COUNT_WIDTH_DEF-1:0]  bin_count;
    logic [HEIGHT_W-1:0]         bar_top;
    logic [COUNT_WIDTH_DEF-1:0]  peak_count;
    logic                        cfg_write;
    logic [CFG_INDEX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;

    int  mismatches;
    int  pending;
    int  reads_checked;
    int  cycles      = 0;
    int  words_sent  = 0;
    int  stall_left  = 0;
    bit  idle_on     = 1'b1;

    always #6 clk = ~clk;

    channel_histogram_with_bar_scaling dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .blue_sample  (blue_sample),
        .green_sample (green_sample),
        .red_sample   (red_sample),
        .query_bin    (query_bin),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bin_number   (bin_number),
        .bin_count    (bin_count),
        .bar_top      (bar_top),
        .peak_count   (peak_count),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    histogram_checker hist_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .blue_sample   (blue_sample),
        .green_sample  (green_sample),
        .red_sample    (red_sample),
        .query_bin     (query_bin),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bin_number    (bin_number),
        .bin_count     (bin_count),
        .bar_top       (bar_top),
        .peak_count    (peak_count),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .reads_checked (reads_checked)
    );

    // Run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("** channel_histogram_with_bar_scaling: FAILED **");
            $finish;
        end
    end

    // Result receiver: stalls come in bursts of random length while idling is on.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready  = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            out_ready  = 1'b0;
        end
        else begin
            out_ready = 1'b1;
        end
    end

    // Present one word, possibly after a gap, and hold it until it is taken.
    task automatic send_word(input logic [MODE_W-1:0]   m,
                             input logic [SAMPLE_W-1:0] b,
                             input logic [SAMPLE_W-1:0] g,
                             input logic [SAMPLE_W-1:0] r,
                             input logic [SAMPLE_W-1:0] q);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid     = 1'b1;
        mode         = m;
        blue_sample  = b;
        green_sample = g;
        red_sample   = r;
        query_bin    = q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    // Wait for every expected result, then let any pixel or clear word drain.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles.
    task automatic configure(input logic [CFG_DATA_W-1:0] channel_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        cfg_write = 1'b1;
        cfg_index = REG_CHANNEL_SELECT;
        cfg_data  = channel_data;
        @(negedge clk);
        cfg_index = REG_CANVAS_HEIGHT;
        cfg_data  = height_data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial begin
        logic [CHANNEL_W-1:0] channel_plan [4];
        logic [HEIGHT_W-1:0]  height_plan [4];
        logic [CHANNEL_W-1:0] ch;
        logic [HEIGHT_W-1:0]  h;
        logic [SAMPLE_W-1:0]  hot;
        logic [SAMPLE_W-1:0]  b;
        logic [SAMPLE_W-1:0]  g;
        logic [SAMPLE_W-1:0]  r;
        logic [SAMPLE_W-1:0]  q;
        int                   sent;
        int                   pick;

        channel_plan = '{CH_BLUE, CH_GREEN, CH_RED, CH_UNUSED};
        height_plan  = '{10'd1023, 10'd0, 10'd1, 10'd125};

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_COUNT;
        blue_sample  = '0;
        green_sample = '0;
        red_sample   = '0;
        query_bin    = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_CHANNEL_SELECT;
        cfg_data     = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: blue channel, canvas of 125 rows; extreme bins and samples.
        send_word(MODE_COUNT,  8'd0,   8'd255, 8'd255, 8'd255);
        send_word(MODE_COUNT,  8'd255, 8'd0,   8'd0,   8'd0);
        send_word(MODE_COUNT,  8'd255, 8'd0,   8'd0,   8'd0);
        send_word(MODE_READ,   8'd255, 8'd255, 8'd255, 8'd0);
        send_word(MODE_READ,   8'd0,   8'd0,   8'd0,   8'd255);
        send_word(MODE_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(MODE_READ,   8'd0,   8'd0,   8'd0,   8'd128);
        send_word(MODE_CLEAR,  8'd255, 8'd255, 8'd255, 8'd255);
        send_word(MODE_READ,   8'd0,   8'd0,   8'd0,   8'd255);

        // Green channel, with the unused upper data bits set.
        settle();
        configure({8'hFF, CH_GREEN}, 10'd125);
        send_word(MODE_COUNT, 8'd1, 8'd200, 8'd3, 8'd0);
        send_word(MODE_COUNT, 8'd1, 8'd200, 8'd3, 8'd0);
        send_word(MODE_READ,  8'd0, 8'd0,   8'd0, 8'd200);
        send_word(MODE_READ,  8'd0, 8'd0,   8'd0, 8'd1);

        // Red channel on a one-row canvas, so the peak exceeds the height.
        settle();
        configure({8'h00, CH_RED}, 10'd1);
        send_word(MODE_COUNT, 8'd0, 8'd0, 8'd7, 8'd0);
        send_word(MODE_COUNT, 8'd0, 8'd0, 8'd7, 8'd0);
        send_word(MODE_COUNT, 8'd0, 8'd0, 8'd7, 8'd0);
        send_word(MODE_READ,  8'd0, 8'd0, 8'd0, 8'd7);
        send_word(MODE_READ,  8'd0, 8'd0, 8'd0, 8'd200);

        // Unused channel code counts blue; a zero-height canvas gives bar row zero.
        settle();
        configure({8'hFF, CH_UNUSED}, 10'd0);
        send_word(MODE_COUNT, 8'd9, 8'd0, 8'd0, 8'd0);
        send_word(MODE_READ,  8'd0, 8'd0, 8'd0, 8'd9);

        // Tallest canvas.
        settle();
        configure({8'h5A, CH_BLUE}, 10'd1023);
        send_word(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd200);
        send_word(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd9);

        // Random phases: pixels favour one hot bin per phase so the peak climbs
        // above small canvases; reads mostly hit that bin; clears are rare.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            ch = (p < 4) ? channel_plan[p] : channel_plan[$urandom_range(0, 3)];
            h  = (p < 4) ? height_plan[p] : HEIGHT_W'($urandom_range(2, 90));
            configure({8'($urandom), ch}, h);
            idle_on = (p != PHASES - 1);
            hot     = 8'($urandom);
            sent    = 0;
            while (sent < WORDS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                b    = 8'($urandom);
                g    = 8'($urandom);
                r    = 8'($urandom);
                q    = $urandom_range(0, 1) ? hot : 8'($urandom);
                if (pick < 40) begin
                    case (ch)
                        CH_GREEN: g = hot;
                        CH_RED:   r = hot;
                        default:  b = hot;
                    endcase
                end
                if (pick < 72 || pick == 99) begin
                    send_word(MODE_COUNT, b, g, r, q);
                    sent++;
                end
                else if (pick < 95) begin
                    send_word(MODE_READ, b, g, r, q);
                    sent++;
                end
                else if (pick < 98) begin
                    send_word(MODE_UNUSED, b, g, r, q);
                end
                else begin
                    send_word(MODE_CLEAR, b, g, r, q);
                    sent++;
                end
            end
        end

        settle();
        $display("Sent %0d words over %0d register settings, all channel codes and modes,",
                 words_sent, PHASES + 5);
        $display("canvas heights 0 to 1023; %0d read results checked, %0d mismatches.",
                 reads_checked, mismatches);
        if (mismatches == 0)
            $display("** channel_histogram_with_bar_scaling: PASSED **");
        else
            $display("** channel_histogram_with_bar_scaling: FAILED **");
        $finish;
    end

endmodule
